// File: rtl/gfwr_pkg.sv
// Shared types and constants for the full-weighting grid restriction block.
// Holds the cell payload structs, the stencil kind codes and the lane control struct.
// Depends on nothing; every file that uses it refers to it by scoped names.
package gfwr_pkg;

	localparam int MAX_FINE_SIZE_DEF = 256;
	localparam int DATA_W = 32;
	localparam int NUM_LANES = 4;
	localparam int POS_W = 9;
	localparam int COORD_W = 8;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 9;
	localparam int AREA_SHIFT = 4;
	localparam int LINE_SHIFT = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_FINE_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FINE_HEIGHT = 1'b1;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic signed [DATA_W-1:0] sample_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_INTERIOR,
		KIND_ROW_GHOST,
		KIND_COL_GHOST
	} kind_t;

	typedef struct packed {
		sample_t planck_value;
		sample_t source_value;
		sample_t destruction_value;
		sample_t opacity_value;
	} fine_cell_t;

	typedef struct packed {
		coord_t  coarse_row;
		coord_t  coarse_col;
		sample_t planck_out;
		sample_t source_out;
		sample_t destruction_out;
		sample_t opacity_out;
		logic    frame_done;
	} coarse_cell_t;

	typedef struct packed {
		logic  s1_move;
		kind_t kind_s2;
	} lane_ctrl_t;

endpackage

// File: rtl/gfwr_if.sv
// Valid/ready stream interfaces for fine input cells and coarse result cells.
// Depends on gfwr_pkg for the payload structs.
interface fine_cell_if;
	logic                   valid;
	logic                   ready;
	gfwr_pkg::fine_cell_t   data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface coarse_cell_if;
	logic                   valid;
	logic                   ready;
	gfwr_pkg::coarse_cell_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/grid_full_weighting_restrict.sv
// Top level of the 2x full-weighting restriction: raster control, line buffers, lanes.
// Depends on gfwr_pkg, gfwr_if, gfwr_ram and gfwr_lane.
//
//   port     direction  payload        transaction
//   fine     in         fine_cell_t    one fine cell, raster order, ghost ring included
//   coarse   out        coarse_cell_t  one coarse cell with its coordinates
//   wr_*     in         index, data    register write, one per cycle with wr_en
//
// One fine cell is accepted per clock while the output is not stalled; the cell that
// completes a result passes the line buffer read, column sum and weighting registers.
// The rate is set by the single read and write port of each line buffer per cycle.
// Reset clears the raster position and the pipeline valids; the line buffers start
// unwritten and need no clearing pass. A stalled output holds the pipeline behind it.
module grid_full_weighting_restrict #(
	parameter int MAX_FINE_SIZE = gfwr_pkg::MAX_FINE_SIZE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	fine_cell_if.sink                           fine,
	coarse_cell_if.source                       coarse,
	input  logic                                wr_en,
	input  logic [gfwr_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [gfwr_pkg::CFG_DATA_W-1:0]     wr_data
);

	localparam int LineLen = MAX_FINE_SIZE + 2;
	localparam int AddrW = $clog2(LineLen);
	localparam int WordW = gfwr_pkg::DATA_W * gfwr_pkg::NUM_LANES;
	localparam int PosMax = (1 << gfwr_pkg::POS_W) - 2;
	localparam int EvenMax = (MAX_FINE_SIZE / 2) * 2;
	localparam int CapInt = (EvenMax > PosMax) ? PosMax : EvenMax;
	localparam gfwr_pkg::pos_t SizeCap = gfwr_pkg::POS_W'(CapInt);
	localparam gfwr_pkg::pos_t SizeMin = gfwr_pkg::POS_W'(2);

	function automatic gfwr_pkg::pos_t eff_size(input logic [gfwr_pkg::CFG_DATA_W-1:0] v);
		gfwr_pkg::pos_t e;
		e = {v[gfwr_pkg::POS_W-1:1], 1'b0};
		if (e < SizeMin) e = SizeMin;
		if (e > SizeCap) e = SizeCap;
		return e;
	endfunction

	gfwr_pkg::pos_t w_q, h_q, row_q, col_q;
	gfwr_pkg::pos_t w_p1, h_p1;
	logic           accept;

	// Stage registers.
	logic                 valid_s1, valid_s2, out_valid_q;
	gfwr_pkg::fine_cell_t cell_s1;
	logic                 par_s1;
	gfwr_pkg::kind_t      kind_s1, kind_s2, kind_now;
	gfwr_pkg::coord_t     crow_s1, ccol_s1, crow_s2, ccol_s2, crow_now, ccol_now;
	logic                 done_s1, done_s2, done_now;
	gfwr_pkg::coarse_cell_t out_q;

	logic out_free, s2_free, s1_move, s2_move;

	logic [WordW-1:0] wdata, rd0, rd1, top_word, mid_word;
	gfwr_pkg::sample_t bot_val [gfwr_pkg::NUM_LANES];
	gfwr_pkg::sample_t res [gfwr_pkg::NUM_LANES];
	gfwr_pkg::lane_ctrl_t lane_ctrl;

	assign w_p1 = w_q + gfwr_pkg::POS_W'(1);
	assign h_p1 = h_q + gfwr_pkg::POS_W'(1);

	// Handshake chain: each stage moves when the one after it has room.
	assign out_free = !out_valid_q || coarse.ready;
	assign s2_move = valid_s2 && out_free;
	assign s2_free = !valid_s2 || out_free;
	assign s1_move = valid_s1 && s2_free;
	assign fine.ready = !valid_s1 || s2_free;
	assign accept = fine.valid && fine.ready;

	// Classify the arriving cell by its raster position.
	always_comb begin
		logic r_even, c_even, r_in, c_in;
		r_even = !row_q[0];
		c_even = !col_q[0];
		r_in = (row_q >= SizeMin) && (row_q <= h_q);
		c_in = (col_q >= SizeMin) && (col_q <= w_q);
		kind_now = gfwr_pkg::KIND_NONE;
		crow_now = row_q[gfwr_pkg::POS_W-1:1];
		ccol_now = col_q[gfwr_pkg::POS_W-1:1];
		done_now = 1'b0;
		if (r_even && r_in && c_even && c_in) begin
			kind_now = gfwr_pkg::KIND_INTERIOR;
		end else if (((row_q == '0) || (row_q == h_p1)) && c_even && c_in) begin
			kind_now = gfwr_pkg::KIND_ROW_GHOST;
			crow_now = (row_q == '0) ? '0 :
				gfwr_pkg::COORD_W'(h_q[gfwr_pkg::POS_W-1:1] + 8'd1);
			done_now = (row_q == h_p1) && (col_q == w_q);
		end else if (((col_q == '0) || (col_q == w_p1)) && r_even && r_in) begin
			kind_now = gfwr_pkg::KIND_COL_GHOST;
			ccol_now = (col_q == '0) ? '0 :
				gfwr_pkg::COORD_W'(w_q[gfwr_pkg::POS_W-1:1] + 8'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= gfwr_pkg::POS_W'(16);
			h_q   <= gfwr_pkg::POS_W'(16);
			row_q <= '0;
			col_q <= '0;
		end else if (wr_en) begin
			if (wr_index == gfwr_pkg::CFG_FINE_WIDTH) begin
				w_q <= eff_size(wr_data);
			end
			if (wr_index == gfwr_pkg::CFG_FINE_HEIGHT) begin
				h_q <= eff_size(wr_data);
			end
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_q == w_p1) begin
				col_q <= '0;
				row_q <= (row_q == h_p1) ? '0 : row_q + gfwr_pkg::POS_W'(1);
			end else begin
				col_q <= col_q + gfwr_pkg::POS_W'(1);
			end
		end
	end

	// Line buffers, one per row parity; each holds all four quantities of a fine row.
	assign wdata = {fine.data.opacity_value, fine.data.destruction_value,
		fine.data.source_value, fine.data.planck_value};

	gfwr_ram #(.WIDTH(WordW), .DEPTH(LineLen)) u_line_even (
		.clk(clk), .we(accept && !row_q[0]), .waddr(AddrW'(col_q)), .wdata(wdata),
		.re(accept), .raddr(AddrW'(col_q)), .rdata(rd0)
	);

	gfwr_ram #(.WIDTH(WordW), .DEPTH(LineLen)) u_line_odd (
		.clk(clk), .we(accept && row_q[0]), .waddr(AddrW'(col_q)), .wdata(wdata),
		.re(accept), .raddr(AddrW'(col_q)), .rdata(rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				valid_s2 <= (kind_s1 != gfwr_pkg::KIND_NONE);
			end else if (s2_move) begin
				valid_s2 <= 1'b0;
			end
			if (s2_move) begin
				out_valid_q <= 1'b1;
			end else if (coarse.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= fine.data;
			par_s1  <= row_q[0];
			kind_s1 <= kind_now;
			crow_s1 <= crow_now;
			ccol_s1 <= ccol_now;
			done_s1 <= done_now;
		end
		if (s1_move) begin
			kind_s2 <= kind_s1;
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;
			done_s2 <= done_s1;
		end
		if (s2_move) begin
			out_q.coarse_row      <= crow_s2;
			out_q.coarse_col      <= ccol_s2;
			out_q.planck_out      <= res[0];
			out_q.source_out      <= res[1];
			out_q.destruction_out <= res[2];
			out_q.opacity_out     <= res[3];
			out_q.frame_done      <= done_s2;
		end
	end

	// The buffer of the current row's parity still holds the row two above.
	assign top_word = par_s1 ? rd1 : rd0;
	assign mid_word = par_s1 ? rd0 : rd1;

	always_comb begin
		bot_val[0] = cell_s1.planck_value;
		bot_val[1] = cell_s1.source_value;
		bot_val[2] = cell_s1.destruction_value;
		bot_val[3] = cell_s1.opacity_value;
	end

	assign lane_ctrl.s1_move = s1_move;
	assign lane_ctrl.kind_s2 = kind_s2;

	for (genvar i = 0; i < gfwr_pkg::NUM_LANES; i++) begin : g_lane
		gfwr_lane u_lane (
			.clk(clk),
			.ctrl(lane_ctrl),
			.top_val(top_word[i*gfwr_pkg::DATA_W +: gfwr_pkg::DATA_W]),
			.mid_val(mid_word[i*gfwr_pkg::DATA_W +: gfwr_pkg::DATA_W]),
			.bot_val(bot_val[i]),
			.result(res[i])
		);
	end

	assign coarse.valid = out_valid_q;
	assign coarse.data = out_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= h_p1) && (col_q <= w_p1))
		else $error("raster position beyond the configured frame");

	a_s2_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (kind_s2 != gfwr_pkg::KIND_NONE))
		else $error("non-emitting cell reached the weighting stage");

	a_done_col: assert property (@(posedge clk) disable iff (!arst_n)
		(coarse.valid && coarse.data.frame_done) |->
		(coarse.data.coarse_col == w_q[gfwr_pkg::POS_W-1:1]))
		else $error("frame end flagged away from the last coarse column");

	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_free) |-> !accept)
		else $error("cell accepted while the first stage was blocked");

endmodule

// File: rtl/gfwr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read of the address written in the same cycle returns the old contents.
// No dependencies.
module gfwr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/gfwr_lane.sv
// One quantity lane: column sums, a two-column window and the final weighting.
// Stage 1 forms the vertical (1,2,1) sum; stage 2 weights by kind: both directions inside, one line for ghosts.
// Depends on gfwr_pkg.
module gfwr_lane (
	input  logic                 clk,
	input  gfwr_pkg::lane_ctrl_t ctrl,
	input  gfwr_pkg::sample_t    top_val,
	input  gfwr_pkg::sample_t    mid_val,
	input  gfwr_pkg::sample_t    bot_val,
	output gfwr_pkg::sample_t    result
);

	localparam int ColW = gfwr_pkg::DATA_W + 2;
	localparam int AreaW = gfwr_pkg::DATA_W + 4;

	logic signed [ColW-1:0]  vsum_now;
	logic signed [ColW-1:0]  vs1_q, vs2_q;
	logic signed [ColW-1:0]  vs0_s2, vs1_s2, vs2_s2;
	gfwr_pkg::sample_t       bt1_q, bt2_q;
	gfwr_pkg::sample_t       bt0_s2, bt1_s2, bt2_s2;
	logic signed [AreaW-1:0] area_sum, area_shift;
	logic signed [ColW-1:0]  line_sum, line_shift, col_shift;

	assign vsum_now = ColW'(top_val) + (ColW'(mid_val) <<< 1) + ColW'(bot_val);

	// The window keeps the column sums and bottom values of the two previous cells.
	always_ff @(posedge clk) begin
		if (ctrl.s1_move) begin
			vs1_q  <= vsum_now;
			vs2_q  <= vs1_q;
			bt1_q  <= bot_val;
			bt2_q  <= bt1_q;
			vs0_s2 <= vsum_now;
			vs1_s2 <= vs1_q;
			vs2_s2 <= vs2_q;
			bt0_s2 <= bot_val;
			bt1_s2 <= bt1_q;
			bt2_s2 <= bt2_q;
		end
	end

	assign area_sum = AreaW'(vs2_s2) + (AreaW'(vs1_s2) <<< 1) + AreaW'(vs0_s2);
	assign line_sum = ColW'(bt2_s2) + (ColW'(bt1_s2) <<< 1) + ColW'(bt0_s2);
	assign area_shift = area_sum >>> gfwr_pkg::AREA_SHIFT;
	assign line_shift = line_sum >>> gfwr_pkg::LINE_SHIFT;
	assign col_shift = vs0_s2 >>> gfwr_pkg::LINE_SHIFT;

	always_comb begin
		case (ctrl.kind_s2)
			gfwr_pkg::KIND_INTERIOR:  result = area_shift[gfwr_pkg::DATA_W-1:0];
			gfwr_pkg::KIND_ROW_GHOST: result = line_shift[gfwr_pkg::DATA_W-1:0];
			gfwr_pkg::KIND_COL_GHOST: result = col_shift[gfwr_pkg::DATA_W-1:0];
			default:                  result = '0;
		endcase
	end

endmodule

// File: tb/tb.sv
// Self-checking testbench for grid_full_weighting_restrict: drives fine cells in raster order
// and checks every coarse result against a line-buffered stencil predictor kept here.
// Depends on gfwr_pkg, the stream interfaces in gfwr_if and the top level of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LEN = gfwr_pkg::MAX_FINE_SIZE_DEF + 2;
	localparam int SIZE_CAP = gfwr_pkg::MAX_FINE_SIZE_DEF & ~1;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam gfwr_pkg::sample_t EDGE_VALUES [8] = '{
		32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'shFFFFFFFF,
		32'sh00000001, 32'sh00010000, 32'shFFFF0000, 32'sh55555555
	};

	class restrict_scoreboard;
		logic [gfwr_pkg::CFG_DATA_W-1:0] width_reg;
		logic [gfwr_pkg::CFG_DATA_W-1:0] height_reg;
		int unsigned row_pos;
		int unsigned col_pos;
		gfwr_pkg::sample_t line_store [gfwr_pkg::NUM_LANES][2*LINE_LEN];
		// Per quantity and window row: [0] is the previous column, [1] the one before.
		gfwr_pkg::sample_t recent_cols [gfwr_pkg::NUM_LANES][3][2];
		gfwr_pkg::coarse_cell_t coarse_due [$];
		int unsigned mismatches;
		int unsigned results_seen;
		int unsigned frames_closed;

		function new();
			width_reg = 16;
			height_reg = 16;
			row_pos = 0;
			col_pos = 0;
			mismatches = 0;
			results_seen = 0;
			frames_closed = 0;
			foreach (line_store[q, i]) line_store[q][i] = '0;
			foreach (recent_cols[q, k, a]) recent_cols[q][k][a] = '0;
		endfunction

		function int unsigned eff_size(logic [gfwr_pkg::CFG_DATA_W-1:0] reg_v);
			int unsigned v;
			v = reg_v & ~9'd1;
			if (v < 2) v = 2;
			if (v > SIZE_CAP) v = SIZE_CAP;
			return v;
		endfunction

		function int pending();
			return coarse_due.size();
		endfunction

		// Any register write restarts the frame at the top left ghost cell.
		function void write_reg(logic [gfwr_pkg::CFG_INDEX_W-1:0] index,
				logic [gfwr_pkg::CFG_DATA_W-1:0] value);
			if (index == gfwr_pkg::CFG_FINE_WIDTH) width_reg = value;
			else height_reg = value;
			row_pos = 0;
			col_pos = 0;
		endfunction

		function void note_cell(gfwr_pkg::fine_cell_t fine_item);
			int unsigned w, h, r, c, crow, ccol;
			int q, k;
			longint g [gfwr_pkg::NUM_LANES][3][3];
			gfwr_pkg::sample_t incoming [gfwr_pkg::NUM_LANES];
			gfwr_pkg::sample_t sums [gfwr_pkg::NUM_LANES];
			longint acc;
			gfwr_pkg::kind_t kind;
			gfwr_pkg::coarse_cell_t want;
			w = eff_size(width_reg);
			h = eff_size(height_reg);
			r = row_pos;
			c = col_pos;
			crow = 0;
			ccol = 0;
			incoming = '{fine_item.planck_value, fine_item.source_value,
				fine_item.destruction_value, fine_item.opacity_value};
			for (q = 0; q < gfwr_pkg::NUM_LANES; q++) begin
				g[q][0][2] = line_store[q][(r % 2) * LINE_LEN + c];
				g[q][1][2] = line_store[q][((r + 1) % 2) * LINE_LEN + c];
				g[q][2][2] = incoming[q];
				for (k = 0; k < 3; k++) begin
					g[q][k][1] = recent_cols[q][k][0];
					g[q][k][0] = recent_cols[q][k][1];
				end
			end

			kind = gfwr_pkg::KIND_NONE;
			if (r % 2 == 0 && r >= 2 && r <= h && c % 2 == 0 && c >= 2 && c <= w) begin
				kind = gfwr_pkg::KIND_INTERIOR;
				crow = r / 2;
				ccol = c / 2;
			end else if ((r == 0 || r == h + 1) && c % 2 == 0 && c >= 2 && c <= w) begin
				kind = gfwr_pkg::KIND_ROW_GHOST;
				crow = (r == 0) ? 0 : h / 2 + 1;
				ccol = c / 2;
			end else if ((c == 0 || c == w + 1) && r % 2 == 0 && r >= 2 && r <= h) begin
				kind = gfwr_pkg::KIND_COL_GHOST;
				crow = r / 2;
				ccol = (c == 0) ? 0 : w / 2 + 1;
			end

			// Sums are exact in 64 bits; the arithmetic shift gives the floor.
			for (q = 0; q < gfwr_pkg::NUM_LANES; q++) begin
				case (kind)
					gfwr_pkg::KIND_INTERIOR: begin
						acc = g[q][0][0] + g[q][0][2] + g[q][2][0] + g[q][2][2]
							+ 2 * (g[q][0][1] + g[q][1][0] + g[q][1][2] + g[q][2][1])
							+ 4 * g[q][1][1];
						acc = acc >>> gfwr_pkg::AREA_SHIFT;
					end
					gfwr_pkg::KIND_ROW_GHOST: begin
						acc = (g[q][2][0] + 2 * g[q][2][1] + g[q][2][2])
							>>> gfwr_pkg::LINE_SHIFT;
					end
					gfwr_pkg::KIND_COL_GHOST: begin
						acc = (g[q][0][2] + 2 * g[q][1][2] + g[q][2][2])
							>>> gfwr_pkg::LINE_SHIFT;
					end
					default: acc = 0;
				endcase
				sums[q] = gfwr_pkg::sample_t'(acc);
			end

			for (q = 0; q < gfwr_pkg::NUM_LANES; q++) begin
				line_store[q][(r % 2) * LINE_LEN + c] = incoming[q];
				for (k = 0; k < 3; k++) begin
					recent_cols[q][k][1] = recent_cols[q][k][0];
					recent_cols[q][k][0] = gfwr_pkg::sample_t'(g[q][k][2]);
				end
			end

			col_pos = col_pos + 1;
			if (col_pos > w + 1) begin
				col_pos = 0;
				row_pos = row_pos + 1;
				if (row_pos > h + 1) row_pos = 0;
			end

			if (kind != gfwr_pkg::KIND_NONE) begin
				want.coarse_row = gfwr_pkg::coord_t'(crow);
				want.coarse_col = gfwr_pkg::coord_t'(ccol);
				want.planck_out = sums[0];
				want.source_out = sums[1];
				want.destruction_out = sums[2];
				want.opacity_out = sums[3];
				want.frame_done = (kind == gfwr_pkg::KIND_ROW_GHOST) && (r == h + 1) && (c == w);
				coarse_due.push_back(want);
			end
		endfunction

		function void check_result(gfwr_pkg::coarse_cell_t got);
			gfwr_pkg::coarse_cell_t want;
			longint want_f [7];
			longint got_f [7];
			string field_name [7];
			field_name = '{"coarse_row", "coarse_col", "planck_out", "source_out",
				"destruction_out", "opacity_out", "frame_done"};
			results_seen++;
			if (coarse_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected coarse result at row %0d col %0d",
						got.coarse_row, got.coarse_col);
				return;
			end
			want = coarse_due.pop_front();
			if (want.frame_done) frames_closed++;
			want_f = '{want.coarse_row, want.coarse_col, want.planck_out, want.source_out,
				want.destruction_out, want.opacity_out, want.frame_done};
			got_f = '{got.coarse_row, got.coarse_col, got.planck_out, got.source_out,
				got.destruction_out, got.opacity_out, got.frame_done};
			foreach (want_f[i]) begin
				if (want_f[i] != got_f[i]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch in %s at coarse (%0d,%0d): expected %0d, got %0d",
							field_name[i], want.coarse_row, want.coarse_col,
							want_f[i], got_f[i]);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [gfwr_pkg::CFG_INDEX_W-1:0] wr_index;
	logic [gfwr_pkg::CFG_DATA_W-1:0] wr_data;

	fine_cell_if fine_ch ();
	coarse_cell_if coarse_ch ();

	restrict_scoreboard sb;
	int unsigned send_idle_pct = 36;
	int unsigned recv_idle_pct = 87;
	int hold_cycles = 0;
	int unsigned cells_sent = 0;
	int unsigned size_settings = 1;

	grid_full_weighting_restrict i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.fine(fine_ch),
		.coarse(coarse_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("timeout: %0d coarse results still outstanding", sb.pending());
		$display("grid_full_weighting_restrict test failed");
		$finish;
	end

	// Result side: samples at the edge, then decides ready for the next cycle.
	initial begin
		coarse_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && coarse_ch.valid && coarse_ch.ready) sb.check_result(coarse_ch.data);
			if (hold_cycles > 0) begin
				hold_cycles--;
				coarse_ch.ready <= 1'b0;
			end else begin
				coarse_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic gfwr_pkg::sample_t random_sample();
		if ($urandom_range(7) == 0) return EDGE_VALUES[$urandom_range(7)];
		return gfwr_pkg::sample_t'($urandom);
	endfunction

	function automatic gfwr_pkg::fine_cell_t random_cell();
		gfwr_pkg::fine_cell_t fine_item;
		fine_item.planck_value = random_sample();
		fine_item.source_value = random_sample();
		fine_item.destruction_value = random_sample();
		fine_item.opacity_value = random_sample();
		return fine_item;
	endfunction

	// Planck pinned at the top of the range and source at the bottom reach the extremes of
	// the stencil sums; the other two rotate through mixed signs to exercise the floor on
	// negative sums.
	function automatic gfwr_pkg::fine_cell_t corner_cell(int n);
		gfwr_pkg::fine_cell_t fine_item;
		fine_item.planck_value = EDGE_VALUES[0];
		fine_item.source_value = EDGE_VALUES[1];
		fine_item.destruction_value = EDGE_VALUES[n % 8];
		fine_item.opacity_value = EDGE_VALUES[(n * 3 + 5) % 8];
		return fine_item;
	endfunction

	// Valid stays high from one transaction into the next unless the sender idles.
	task automatic send_cell(input gfwr_pkg::fine_cell_t fine_item);
		while ($urandom_range(99) < send_idle_pct) begin
			fine_ch.valid <= 1'b0;
			@(posedge clk);
		end
		fine_ch.valid <= 1'b1;
		fine_ch.data <= fine_item;
		do @(posedge clk); while (!fine_ch.ready);
		sb.note_cell(fine_item);
		cells_sent++;
	endtask

	task automatic drain_results();
		fine_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic apply_sizes(input logic [gfwr_pkg::CFG_DATA_W-1:0] w,
			input logic [gfwr_pkg::CFG_DATA_W-1:0] h);
		drain_results();
		// Trailing cells that complete nothing may still be in the pipeline.
		repeat (SETTLE_CYCLES) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= gfwr_pkg::CFG_FINE_WIDTH;
		wr_data <= w;
		@(posedge clk);
		sb.write_reg(gfwr_pkg::CFG_FINE_WIDTH, w);
		wr_index <= gfwr_pkg::CFG_FINE_HEIGHT;
		wr_data <= h;
		@(posedge clk);
		sb.write_reg(gfwr_pkg::CFG_FINE_HEIGHT, h);
		wr_en <= 1'b0;
		size_settings++;
	endtask

	task automatic run_phase(input logic [gfwr_pkg::CFG_DATA_W-1:0] w,
			input logic [gfwr_pkg::CFG_DATA_W-1:0] h,
			input int n, input int pause_at, input int hold_at);
		apply_sizes(w, h);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) drain_results();
			if (i == hold_at) hold_cycles = HOLD_OFF_CYCLES;
			send_cell(random_cell());
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= gfwr_pkg::CFG_FINE_WIDTH;
		wr_data <= '0;
		fine_ch.valid <= 1'b0;
		fine_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: part of the top ghost row, then a restart into a minimal frame,
		// which produces every kind of result and the end of frame flag.
		for (int i = 0; i < 10; i++) send_cell(corner_cell(i));
		apply_sizes(9'd2, 9'd2);
		for (int i = 0; i < 16; i++) send_cell(corner_cell(i + 10));

		run_phase(9'd3, 9'd1, 48, -1, -1);
		run_phase(9'd6, 9'd4, 150, 75, -1);

		send_idle_pct = 87;
		recv_idle_pct = 36;
		run_phase(9'd10, 9'd8, 130, -1, -1);
		// The widest row reaches the last line buffer address.
		run_phase(9'd511, 9'd0, 270, -1, -1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(9'd4, 9'd300, 180, -1, 20);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d fine cells over %0d grid size settings; %0d coarse results checked.",
			cells_sent, size_settings, sb.results_seen);
		$display("Full frames closed: %0d; field mismatches: %0d.",
			sb.frames_closed, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("grid_full_weighting_restrict test passed");
		end else begin
			$display("grid_full_weighting_restrict test failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/gfwr_pkg.sv
rtl/gfwr_if.sv
rtl/gfwr_ram.sv
rtl/gfwr_lane.sv
rtl/grid_full_weighting_restrict.sv
tb/tb.sv
